[rtl/core/encdet_pkg.sv]
package encdet_pkg;

	// Field and state widths
	localparam int COUNT_BITS = 16;
	localparam int STEP_BITS  = 32;
	localparam int CPS_BITS   = 8;
	localparam int REM_BITS   = CPS_BITS + 1;
	localparam int ITER_BITS  = $clog2(COUNT_BITS);

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] REG_DETENT_SIZE      = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_INVERT_DIRECTION = 1'd1;

	localparam logic [CPS_BITS-1:0] CPS_RESET = 8'd2;

	// Input kinds
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	// Request into the divide unit
	typedef struct packed {
		logic                  start;
		logic [COUNT_BITS-1:0] dividend;
		logic [CPS_BITS-1:0]   divisor;
	} div_req_t;

	// Result from the divide unit
	typedef struct packed {
		logic                  done;
		logic [COUNT_BITS-1:0] quotient;
		logic [CPS_BITS-1:0]   remainder;
	} div_rsp_t;

endpackage

[rtl/core/encdet_div.sv]
module encdet_div
	import encdet_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                  busy_q;
	logic [ITER_BITS-1:0]  cnt_q;
	logic [COUNT_BITS-1:0] quo_q;
	logic [CPS_BITS-1:0]   rem_q;
	logic [CPS_BITS-1:0]   div_q;
	logic                  done_q;

	logic [CPS_BITS:0]     shifted;
	logic [CPS_BITS+1:0]   diff;
	logic                  ge;

	// One restoring step: shift in next dividend bit, trial subtract
	always_comb begin
		shifted = {rem_q, quo_q[COUNT_BITS-1]};
		diff    = {1'b0, shifted} - {2'b00, div_q};
		ge      = ~diff[CPS_BITS+1];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ITER_BITS'(COUNT_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[COUNT_BITS-2:0], ge};
			rem_q <= ge ? diff[CPS_BITS-1:0] : shifted[CPS_BITS-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

[rtl/core/encoder_count_to_detent_steps.sv]
// Channel   Dir  Word                        Sideband
// s_*       in   tdata[15:0] counter_value   tuser[0] action (0 sample, 1 read)
// m_*       out  tdata[31:0] steps_read      tuser[0] steps_changed
// cfg_*     in   write of detent size (0) / invert_direction (1)
//
// A sample with nonzero delta runs through the bit-serial divider (one
// quotient bit per cycle), a step to see it finish and a step to update
// the total and load the output; s_tready stays low until then, so the block
// takes no new word until it is through with the last. Reads and zero-delta
// samples skip the divider and go straight to the update step.
// Reset clears the last count, remainder, total and registers to defaults.
// A result waits in the output register while m_tready is low; the block
// still takes the next word and holds it at the finish step until the
// output register is free.
module encoder_count_to_detent_steps
	import encdet_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [COUNT_BITS-1:0]   s_tdata,   // [15:0] counter_value
	input  logic                    s_tuser,   // [0] action
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [STEP_BITS-1:0]    m_tdata,   // [31:0] steps_read
	output logic                    m_tuser,   // [0] steps_changed
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CPS_BITS-1:0]     cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]            state_q;
	logic [CPS_BITS-1:0]   cps_q;
	logic                  invert_q;
	logic [COUNT_BITS-1:0] last_q;
	logic [REM_BITS-1:0]   rem_q;
	logic [STEP_BITS-1:0]  total_q;
	logic                  read_q;
	logic                  nz_q;
	logic                  neg_q;
	logic                  out_valid_q;
	logic [STEP_BITS-1:0]  out_data_q;
	logic                  out_chg_q;

	logic                    accept;
	logic [COUNT_BITS-1:0]   delta;
	logic [COUNT_BITS:0]     delta_x;
	logic [COUNT_BITS+1:0]   sum;
	logic [COUNT_BITS+1:0]   mag;
	logic [CPS_BITS-1:0]     cps_eff;
	logic                    out_free;
	logic [COUNT_BITS:0]     whole;
	logic [REM_BITS-1:0]     rem_new;
	logic [STEP_BITS-1:0]    total_new;
	div_req_t                dreq;
	div_rsp_t                drsp;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// Wrapped delta, direction, remainder add, magnitude and effective divisor
	always_comb begin
		delta   = s_tdata - last_q;
		delta_x = invert_q ? -{delta[COUNT_BITS-1], delta} : {delta[COUNT_BITS-1], delta};
		sum     = {{(COUNT_BITS+2-REM_BITS){rem_q[REM_BITS-1]}}, rem_q}
		        + {delta_x[COUNT_BITS], delta_x};
		mag     = sum[COUNT_BITS+1] ? -sum : sum;
		cps_eff = (cps_q == '0) ? CPS_BITS'(1) : cps_q;
	end

	always_comb begin
		dreq.start    = accept && (s_tuser == ACT_SAMPLE) && (delta != '0);
		dreq.dividend = mag[COUNT_BITS-1:0];
		dreq.divisor  = cps_eff;
	end

	encdet_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// Signed quotient and remainder (truncating), new total
	always_comb begin
		whole     = neg_q ? -{1'b0, drsp.quotient} : {1'b0, drsp.quotient};
		rem_new   = neg_q ? -{1'b0, drsp.remainder} : {1'b0, drsp.remainder};
		total_new = total_q + {{(STEP_BITS-COUNT_BITS-1){whole[COUNT_BITS]}}, whole};
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cps_q    <= CPS_RESET;
			invert_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DETENT_SIZE:      cps_q    <= cfg_data;
				REG_INVERT_DIRECTION: invert_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= '0;
			rem_q       <= '0;
			total_q     <= '0;
			read_q      <= 1'b0;
			nz_q        <= 1'b0;
			neg_q       <= 1'b0;
			out_chg_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						read_q <= (s_tuser == ACT_READ);
						nz_q   <= (delta != '0);
						neg_q  <= sum[COUNT_BITS+1];
						if (s_tuser == ACT_SAMPLE) begin
							last_q <= s_tdata;
						end
						state_q <= dreq.start ? ST_DIV : ST_FIN;
					end
				end
				ST_DIV: begin
					if (drsp.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (read_q) begin
							out_chg_q <= 1'b0;
							total_q   <= '0;
						end else if (nz_q) begin
							out_chg_q <= (drsp.quotient != '0);
							total_q   <= total_new;
							rem_q     <= rem_new;
						end else begin
							out_chg_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output valid: set when a result is loaded, cleared when it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word
	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			out_data_q <= (!read_q && nz_q) ? total_new : total_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_chg_q;

endmodule

[tb/sv/tb_encoder_count_to_detent_steps.sv]
module tb_encoder_count_to_detent_steps
	import encdet_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES  = 300;

	// One result word: total and change flag
	typedef struct packed {
		logic [STEP_BITS-1:0] steps_read;
		logic                 steps_changed;
	} detent_word_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [COUNT_BITS-1:0]   s_tdata   = '0;   // [15:0] counter_value
	logic                    s_tuser   = ACT_SAMPLE; // [0] action
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	logic [STEP_BITS-1:0]    m_tdata;          // [31:0] steps_read
	logic                    m_tuser;          // [0] steps_changed
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = REG_DETENT_SIZE;
	logic [CPS_BITS-1:0]     cfg_data  = '0;

	// Predicted block state and settings
	logic [COUNT_BITS-1:0] prev_count     = '0;
	int                    remainder_acc  = 0;
	logic [STEP_BITS-1:0]  step_acc       = '0;
	logic [CPS_BITS-1:0]   cps_reg        = CPS_RESET;
	logic                  invert_reg     = 1'b0;

	detent_word_t expected_words[$];
	int           mismatch_count = 0;
	int           cycle_count    = 0;
	int           send_idle_pct  = 0;
	int           recv_idle_pct  = 0;
	logic         hold_start     = 1'b0;
	int           hold_left      = 0;

	encoder_count_to_detent_steps DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Timeout
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Next total for one accepted word; truncating division keeps the
	// remainder strictly inside +/- the divisor
	function automatic detent_word_t predict_detent_word(input logic act,
			input logic [COUNT_BITS-1:0] count);
		detent_word_t              w;
		logic signed [COUNT_BITS-1:0] diff;
		int                        delta;
		int                        divisor;
		int                        sum;
		int                        whole;
		logic [STEP_BITS-1:0]      prior;
		w.steps_changed = 1'b0;
		if (act == ACT_READ) begin
			w.steps_read = step_acc;
			step_acc = '0;
			return w;
		end
		diff = count - prev_count;
		prev_count = count;
		if (diff != 0) begin
			delta = diff;
			if (invert_reg)
				delta = -delta;
			// zero counts per step acts as one
			divisor = (cps_reg == '0) ? 1 : int'(cps_reg);
			sum = remainder_acc + delta;
			whole = sum / divisor;
			remainder_acc = sum - whole * divisor;
			prior = step_acc;
			step_acc = step_acc + whole;
			w.steps_changed = (step_acc != prior);
		end
		w.steps_read = step_acc;
		return w;
	endfunction

	// Result check
	always @(posedge clk) begin
		detent_word_t want;
		if (m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				$error("result word with none expected: steps_read %0d steps_changed %0b",
					$signed(m_tdata), m_tuser);
				mismatch_count++;
			end else begin
				want = expected_words.pop_front();
				if (m_tdata !== want.steps_read) begin
					$error("steps_read mismatch: expected %0d, actual %0d",
						$signed(want.steps_read), $signed(m_tdata));
					mismatch_count++;
				end
				if (m_tuser !== want.steps_changed) begin
					$error("steps_changed mismatch: expected %0b, actual %0b",
						want.steps_changed, m_tuser);
					mismatch_count++;
				end
			end
		end
	end

	// Output stall control: random idling plus one long hold
	always @(posedge clk) begin
		if (hold_start)
			hold_left = HOLD_CYCLES;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one word, wait for the handshake, log its expected result
	task automatic send_detent_word(input logic act, input logic [COUNT_BITS-1:0] count);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= count;
		do @(posedge clk); while (!s_tready);
		expected_words.push_back(predict_detent_word(act, count));
	endtask

	// Stop offering and wait until every result has been handed over
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CPS_BITS-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DETENT_SIZE)
			cps_reg = value;
		else
			invert_reg = value[0];
		@(posedge clk);
	endtask

	// Drain, then write both registers; upper bits of the invert word are noise
	task automatic apply_settings(input logic [CPS_BITS-1:0] cps, input logic inv);
		logic [CPS_BITS-1:0] inv_word;
		drain_results();
		inv_word = CPS_BITS'($urandom);
		inv_word[0] = inv;
		write_register(REG_DETENT_SIZE, cps);
		write_register(REG_INVERT_DIRECTION, inv_word);
	endtask

	// Mostly small moves around the last count, plus repeats, jumps and reads
	task automatic run_random_words(input int n);
		logic                  act;
		logic [COUNT_BITS-1:0] count;
		int                    pick;
		repeat (n) begin
			act = ($urandom_range(99) < 15) ? ACT_READ : ACT_SAMPLE;
			pick = $urandom_range(99);
			if (pick < 10)
				count = prev_count;
			else if (pick < 25)
				count = COUNT_BITS'($urandom);
			else if (pick < 90)
				count = COUNT_BITS'(prev_count + $urandom_range(300) - 150);
			else
				count = COUNT_BITS'(prev_count + 16'h8000 + $urandom_range(8) - 4);
			send_detent_word(act, count);
		end
	endtask

	// Default settings: counts per step two, no inversion
	task automatic test_reset_defaults();
		send_detent_word(ACT_SAMPLE, 16'h0000);
		send_detent_word(ACT_SAMPLE, 16'h0001);
		send_detent_word(ACT_SAMPLE, 16'h0002);
		send_detent_word(ACT_SAMPLE, 16'h0005);
		send_detent_word(ACT_SAMPLE, 16'h0005);
		send_detent_word(ACT_READ,   16'hFFFF);
		send_detent_word(ACT_SAMPLE, 16'hFFFD);
		send_detent_word(ACT_READ,   16'h0000);
		send_detent_word(ACT_READ,   16'h0000);
	endtask

	// Largest deltas both ways, counter wrap, divisor extremes, inversion
	task automatic test_field_extremes();
		apply_settings(8'd1, 1'b0);
		send_detent_word(ACT_SAMPLE, 16'h7FFF);
		send_detent_word(ACT_SAMPLE, 16'hFFFF);
		send_detent_word(ACT_SAMPLE, 16'h0000);
		send_detent_word(ACT_SAMPLE, 16'h8000);
		send_detent_word(ACT_SAMPLE, 16'h8000);
		send_detent_word(ACT_READ,   16'h8000);
		apply_settings(8'd255, 1'b0);
		send_detent_word(ACT_SAMPLE, 16'h80FE);
		send_detent_word(ACT_SAMPLE, 16'h80FF);
		send_detent_word(ACT_SAMPLE, 16'h7F02);
		send_detent_word(ACT_SAMPLE, 16'h0000);
		send_detent_word(ACT_READ,   16'h1234);
		apply_settings(8'd0, 1'b1);
		send_detent_word(ACT_SAMPLE, 16'h0003);
		send_detent_word(ACT_SAMPLE, 16'hFFF0);
		send_detent_word(ACT_READ,   16'h0000);
		apply_settings(8'd3, 1'b1);
		send_detent_word(ACT_SAMPLE, 16'h7FF0);
		send_detent_word(ACT_SAMPLE, 16'h7FF1);
	endtask

	// Random words over three stall mixes, settings changed between chunks
	task automatic test_random_traffic();
		logic [CPS_BITS-1:0] cps_list[9];
		int                  phase;
		int                  chunk;
		cps_list = '{8'd1, 8'd255, 8'd2, 8'd3, 8'd0, 8'd17, 8'd128, 8'd5, 8'd64};
		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 52 : 0;
			recv_idle_pct <= (phase == 0) ? 52 : (phase == 1) ? 9 : 0;
			for (chunk = 0; chunk < 3; chunk++) begin
				if ($urandom_range(3) == 0)
					apply_settings(CPS_BITS'($urandom_range(1, 255)),
						1'($urandom_range(1)));
				else
					apply_settings(cps_list[phase * 3 + chunk], 1'($urandom_range(1)));
				run_random_words(88);
			end
		end
	endtask

	// Long output stall fills the block; then a pause until all has come, then more words
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		run_random_words(16);
		drain_results();
		run_random_words(8);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_field_extremes();
		test_random_traffic();
		test_output_backpressure();
		drain_results();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
